/* hw/rtl/nearest_color_pixel_locator_core_assert.svh */
// Assertion macros shared by the nearest color pixel locator modules.
// Depends on nothing; included by every module that checks its own logic.
`ifndef NEAREST_COLOR_PIXEL_LOCATOR_CORE_ASSERT_SVH
`define NEAREST_COLOR_PIXEL_LOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NCPL_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ncpl: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NCPL_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ncpl: next-cycle check failed");

`endif

/* hw/rtl/ncpl_pkg.sv */
// Package of the nearest color pixel locator: widths and types shared by the
// front, queue and back modules, register codes and the square root step.
package ncpl_pkg;

    // Frame geometry limits.
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);

    // Fixed field widths.
    localparam int CH_W   = 8;
    localparam int THR_W  = 10;
    localparam int FW_W   = 11;
    localparam int POS_W  = 10;
    localparam int IDX_W  = 8;
    localparam int DATA_W = 11;

    // Squared distance and square root pipeline.
    localparam int SQ_W            = 18;
    localparam int SQRT_STEPS      = SQ_W / 2;
    localparam int DIST_W          = SQRT_STEPS;
    localparam int REM_W           = DIST_W + 1;
    localparam int SQRT_STAGES     = 3;
    localparam int STEPS_PER_STAGE = SQRT_STEPS / SQRT_STAGES;

    localparam logic [DIST_W-1:0] MIN_RESET = '1;

    // Queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Register indexes of the configuration port.
    typedef enum logic [IDX_W-1:0] {
        REG_TARGET_BLUE     = 8'd0,
        REG_TARGET_GREEN    = 8'd1,
        REG_TARGET_RED      = 8'd2,
        REG_MATCH_THRESHOLD = 8'd3,
        REG_FRAME_WIDTH     = 8'd4
    } reg_index_t;

    typedef struct packed {
        logic [CH_W-1:0]  target_blue;
        logic [CH_W-1:0]  target_green;
        logic [CH_W-1:0]  target_red;
        logic [THR_W-1:0] match_threshold;
        logic [FW_W-1:0]  frame_width;
    } cfg_t;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            last;
    } pixel_t;

    // One item in the queue: squared distance and the pixel position.
    typedef struct packed {
        logic [SQ_W-1:0]  sumsq;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } q_item_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [DIST_W-1:0] root;
        logic [SQ_W-1:0]   v;
    } sqrt_state_t;

    typedef struct packed {
        sqrt_state_t      sq;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } back_stage_t;

    typedef struct packed {
        logic [POS_W-1:0]  match_column;
        logic [POS_W-1:0]  match_row;
        logic [DIST_W-1:0] best_distance;
        logic              match_found;
    } result_t;

    // One digit of the restoring square root: brings in the next two bits.
    function automatic sqrt_state_t sqrt_step(input sqrt_state_t s);
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        sqrt_state_t      r;
        rem_sh = {s.rem, s.v[SQ_W-1 -: 2]};
        trial  = {1'b0, s.root, 2'b01};
        r.v    = {s.v[SQ_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            r.rem  = REM_W'(rem_sh - trial);
            r.root = {s.root[DIST_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = REM_W'(rem_sh);
            r.root = {s.root[DIST_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

/* hw/rtl/ncpl_if.sv */
// Channel interfaces of the nearest color pixel locator: pixels in, results
// out and register writes. Depends on ncpl_pkg for the field widths.

// Pixel channel.
interface ncpl_pixel_if import ncpl_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] pixel_blue;
    logic [CH_W-1:0] pixel_green;
    logic [CH_W-1:0] pixel_red;
    logic            frame_end;

    modport source (output valid, pixel_blue, pixel_green, pixel_red, frame_end,
                    input ready);
    modport sink (input valid, pixel_blue, pixel_green, pixel_red, frame_end,
                  output ready);
endinterface

// Result channel.
interface ncpl_result_if import ncpl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  match_column;
    logic [POS_W-1:0]  match_row;
    logic [DIST_W-1:0] best_distance;
    logic              match_found;

    modport source (output valid, match_column, match_row, best_distance, match_found,
                    input ready);
    modport sink (input valid, match_column, match_row, best_distance, match_found,
                  output ready);
endinterface

// Register write channel.
interface ncpl_cfg_if import ncpl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/ncpl_front.sv */
// Front of the locator: accepts pixels, tracks column and row, and computes
// the squared color distance in two stages. Depends on ncpl_pkg.
`include "nearest_color_pixel_locator_core_assert.svh"

module ncpl_front import ncpl_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  pixel_t  in_px,
    output logic    q_valid,
    input  logic    q_ready,
    output q_item_t q_item
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W:0]   width_eff;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;

    logic             s1_v_reg, s1_v_next;
    logic [CH_W-1:0]  db_reg, dg_reg, dr_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_last_reg;

    logic             s2_v_reg, s2_v_next;
    q_item_t          s2_item_reg;

    logic             in_fire;
    logic             s2_ld;
    logic             push;
    logic [SQ_W-1:0]  sumsq;

    assign push     = s2_v_reg && q_ready;
    assign s2_ld    = s1_v_reg && (!s2_v_reg || q_ready);
    assign in_ready = !s1_v_reg || !s2_v_reg || q_ready;
    assign in_fire  = in_valid && in_ready;

    // Effective row width: zero acts as one, anything above the limit is clipped.
    always_comb
    begin
        if (cfg.frame_width == '0)
            width_eff = (COL_W+1)'(1);
        else if (32'(cfg.frame_width) > MAX_COLUMNS)
            width_eff = (COL_W+1)'(MAX_COLUMNS);
        else
            width_eff = (COL_W+1)'(cfg.frame_width);
    end

    // Position counters advance per pixel and clear at the frame end.
    always_comb
    begin
        col_inc  = (COL_W+1)'(col_reg) + (COL_W+1)'(1);
        row_inc  = (ROW_W+1)'(row_reg) + (ROW_W+1)'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (in_fire)
        begin
            if (in_px.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_inc >= width_eff)
            begin
                col_next = '0;
                if (row_inc >= (ROW_W+1)'(MAX_ROWS))
                    row_next = '0;
                else
                    row_next = ROW_W'(row_inc);
            end
            else
            begin
                col_next = COL_W'(col_inc);
            end
        end
    end

    // Stage valid bits.
    always_comb
    begin
        s1_v_next = s1_v_reg;
        if (in_fire)
            s1_v_next = 1'b1;
        else if (s2_ld)
            s1_v_next = 1'b0;

        s2_v_next = s2_v_reg;
        if (s2_ld)
            s2_v_next = 1'b1;
        else if (push)
            s2_v_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s2_v_next;
        end
    end

    // Stage one: absolute channel differences.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            db_reg      <= (in_px.blue > cfg.target_blue) ? in_px.blue - cfg.target_blue
                                                          : cfg.target_blue - in_px.blue;
            dg_reg      <= (in_px.green > cfg.target_green) ? in_px.green - cfg.target_green
                                                            : cfg.target_green - in_px.green;
            dr_reg      <= (in_px.red > cfg.target_red) ? in_px.red - cfg.target_red
                                                        : cfg.target_red - in_px.red;
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
            s1_last_reg <= in_px.last;
        end
    end

    // Stage two: sum of the three squares, each product at the full sum width.
    assign sumsq = SQ_W'(db_reg) * SQ_W'(db_reg)
                 + SQ_W'(dg_reg) * SQ_W'(dg_reg)
                 + SQ_W'(dr_reg) * SQ_W'(dr_reg);

    always_ff @(posedge clk)
    begin
        if (s2_ld)
        begin
            s2_item_reg.sumsq <= sumsq;
            s2_item_reg.col   <= s1_col_reg;
            s2_item_reg.row   <= s1_row_reg;
            s2_item_reg.last  <= s1_last_reg;
        end
    end

    assign q_valid = s2_v_reg;
    assign q_item  = s2_item_reg;

    // A frame-end pixel starts the next frame at the origin.
    `NCPL_ASSERT_NEXT(a_pos_clear, clk, rst_n, in_fire && in_px.last, (col_reg == '0) && (row_reg == '0))
    // Stage two never drops an item it still holds.
    `NCPL_ASSERT_NEXT(a_s2_hold, clk, rst_n, s2_v_reg && !q_ready, s2_v_reg)

endmodule

/* hw/rtl/ncpl_fifo.sv */
// Short register queue between the front and the back of the locator.
// Depends on ncpl_pkg for the item type and the depth.
`include "nearest_color_pixel_locator_core_assert.svh"

module ncpl_fifo import ncpl_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  q_item_t push_item,
    output logic    pop_valid,
    input  logic    pop_ready,
    output q_item_t pop_item
);

    localparam int CNT_W = Q_AW + 1;
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(Q_DEPTH);
    localparam logic [Q_AW-1:0]  PTR_LAST = Q_AW'(Q_DEPTH - 1);

    q_item_t          mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push;
    logic             pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + Q_AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + Q_AW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CNT_ONE;
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    // A pop without a push shrinks the queue by one item.
    `NCPL_ASSERT_NEXT(a_pop_count, clk, rst_n, pop && !push, cnt_reg == $past(cnt_reg) - CNT_ONE)
    // The fill count tracks the pointer distance.
    `NCPL_ASSERT_IMPLY(a_ptr_count, clk, rst_n, (cnt_reg == '0) || (cnt_reg == CNT_FULL), wr_ptr_reg == rd_ptr_reg)

endmodule

/* hw/rtl/ncpl_back.sv */
// Back of the locator: pipelined integer square root, running minimum with
// its position, and the result register. Depends on ncpl_pkg.
`include "nearest_color_pixel_locator_core_assert.svh"

module ncpl_back import ncpl_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    q_valid,
    output logic    q_ready,
    input  q_item_t q_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    localparam int LAST_ST = SQRT_STAGES - 1;

    back_stage_t       stage_reg  [SQRT_STAGES];
    back_stage_t       stage_next [SQRT_STAGES];
    logic [SQRT_STAGES-1:0] stage_v_reg;

    logic [DIST_W-1:0] min_reg;
    logic [COL_W-1:0]  best_col_reg;
    logic [ROW_W-1:0]  best_row_reg;
    logic              out_v_reg;
    result_t           out_res_reg;

    logic              adv;
    logic              acc_fire;
    logic              hit;
    logic [DIST_W-1:0] cur_dist;
    logic [DIST_W-1:0] new_min;
    logic [COL_W-1:0]  new_col;
    logic [ROW_W-1:0]  new_row;

    // The whole back stalls only when a frame result finds the output full.
    assign adv      = !(stage_v_reg[LAST_ST] && stage_reg[LAST_ST].last
                        && out_v_reg && !out_ready);
    assign q_ready  = adv;
    assign acc_fire = adv && stage_v_reg[LAST_ST];

    // Square root stages, a few digits each.
    always_comb
    begin
        back_stage_t src;
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            if (k == 0)
            begin
                src.sq.rem  = '0;
                src.sq.root = '0;
                src.sq.v    = q_item.sumsq;
                src.col     = q_item.col;
                src.row     = q_item.row;
                src.last    = q_item.last;
            end
            else
            begin
                src = stage_reg[k-1];
            end
            for (int s = 0; s < STEPS_PER_STAGE; s++)
                src.sq = sqrt_step(src.sq);
            stage_next[k] = src;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_v_reg <= '0;
        else if (adv)
            stage_v_reg <= {stage_v_reg[SQRT_STAGES-2:0], q_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < SQRT_STAGES; k++)
                stage_reg[k] <= stage_next[k];
        end
    end

    // Strictly smaller distance wins, so the first pixel keeps a tie.
    assign cur_dist = stage_reg[LAST_ST].sq.root;
    assign hit      = cur_dist < min_reg;
    assign new_min  = hit ? cur_dist : min_reg;
    assign new_col  = hit ? stage_reg[LAST_ST].col : best_col_reg;
    assign new_row  = hit ? stage_reg[LAST_ST].row : best_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg      <= MIN_RESET;
            best_col_reg <= '0;
            best_row_reg <= '0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            if (acc_fire)
            begin
                if (stage_reg[LAST_ST].last)
                begin
                    min_reg      <= MIN_RESET;
                    best_col_reg <= '0;
                    best_row_reg <= '0;
                end
                else
                begin
                    min_reg      <= new_min;
                    best_col_reg <= new_col;
                    best_row_reg <= new_row;
                end
            end
            if (acc_fire && stage_reg[LAST_ST].last)
                out_v_reg <= 1'b1;
            else if (out_ready)
                out_v_reg <= 1'b0;
        end
    end

    // Result register, loaded at the frame end.
    always_ff @(posedge clk)
    begin
        if (acc_fire && stage_reg[LAST_ST].last)
        begin
            out_res_reg.match_column  <= POS_W'(new_col);
            out_res_reg.match_row     <= POS_W'(new_row);
            out_res_reg.best_distance <= new_min;
            out_res_reg.match_found   <= THR_W'(new_min) < cfg.match_threshold;
        end
    end

    assign out_valid = out_v_reg;
    assign out_res   = out_res_reg;

    // Frame state is back at its reset value after a frame-end item.
    `NCPL_ASSERT_NEXT(a_min_clear, clk, rst_n, acc_fire && stage_reg[LAST_ST].last, min_reg == MIN_RESET)
    // A new result only ever follows a frame-end item leaving the pipeline.
    `NCPL_ASSERT_IMPLY(a_out_src, clk, rst_n, $rose(out_v_reg), $past(stage_v_reg[LAST_ST] && stage_reg[LAST_ST].last))

endmodule

/* hw/rtl/nearest_color_pixel_locator_core.sv */
// Top level of the nearest color pixel locator: register file and the
// front, queue and back. Depends on ncpl_pkg, ncpl_if and the ncpl modules.

// The core takes one pixel per clock and keeps that rate for as long as
// results are taken. A pixel passes two front stages (channel differences,
// then the sum of squares), a four-item queue, three square root stages of
// three digits each and the minimum tracker before its frame result is
// registered. The back holds only while a frame result waits on a full
// output register; the queue takes up that hold, and input ready drops once
// the queue and both front stages are full. Register writes are taken every
// cycle and belong between frames.
module nearest_color_pixel_locator_core import ncpl_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    ncpl_pixel_if.sink    pixels,
    ncpl_result_if.source results,
    ncpl_cfg_if.sink      regs
);

    cfg_t    cfg_reg;
    pixel_t  in_px;
    logic    q_push_valid, q_push_ready;
    q_item_t q_push_item;
    logic    q_pop_valid, q_pop_ready;
    q_item_t q_pop_item;
    result_t res;

    // Register file.
    assign regs.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_blue     <= CH_W'(255);
            cfg_reg.target_green    <= '0;
            cfg_reg.target_red      <= '0;
            cfg_reg.match_threshold <= THR_W'(300);
            cfg_reg.frame_width     <= FW_W'(640);
        end
        else if (regs.valid)
        begin
            unique case (regs.index)
                REG_TARGET_BLUE:     cfg_reg.target_blue     <= regs.data[CH_W-1:0];
                REG_TARGET_GREEN:    cfg_reg.target_green    <= regs.data[CH_W-1:0];
                REG_TARGET_RED:      cfg_reg.target_red      <= regs.data[CH_W-1:0];
                REG_MATCH_THRESHOLD: cfg_reg.match_threshold <= regs.data[THR_W-1:0];
                REG_FRAME_WIDTH:     cfg_reg.frame_width     <= regs.data[FW_W-1:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Input item packing.
    assign in_px.blue  = pixels.pixel_blue;
    assign in_px.green = pixels.pixel_green;
    assign in_px.red   = pixels.pixel_red;
    assign in_px.last  = pixels.frame_end;

    ncpl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (pixels.valid),
        .in_ready (pixels.ready),
        .in_px    (in_px),
        .q_valid  (q_push_valid),
        .q_ready  (q_push_ready),
        .q_item   (q_push_item)
    );

    ncpl_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_item   (q_pop_item)
    );

    ncpl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_pop_valid),
        .q_ready   (q_pop_ready),
        .q_item    (q_pop_item),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_res   (res)
    );

    // Result item unpacking.
    assign results.match_column  = res.match_column;
    assign results.match_row     = res.match_row;
    assign results.best_distance = res.best_distance;
    assign results.match_found   = res.match_found;

endmodule
